/* hdl/assert_macros.svh */
// Assertion macros shared by the timer bank RTL.
// Needs a clk and an active-low arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TMB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer bank assertion failed");
`define TMB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer bank assertion failed");
`else
`define TMB_ASSERT_NOW(lbl, ante, cons)
`define TMB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/tmb_pkg.sv */
// Types and constants of the timer bank.
// No dependencies; used by tmb_front, tmb_back and the top level.
`default_nettype none
package tmb_pkg;

	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_ADD    = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_FIRE   = 2'd2;
	localparam logic [1:0] KIND_DONE   = 2'd3;

	localparam int S_TDATA_W = 88;
	localparam int M_TDATA_W = 48;
	localparam logic [5:0] DIV_STEPS = 6'd33;
	localparam logic [30:0] FIRE_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [1:0]  mode;
		logic [30:0] delta;     // clamped at zero
		logic [30:0] period;
		logic        period_ok; // strictly positive
		logic [15:0] limit;
		logic [3:0]  idx;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic        ok;
		logic [30:0] count;
		logic        fin;
	} event_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_CAP,
		ST_DONE,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

/* hdl/tmb_front.sv */
// Front end: accepts input transfers, classifies them and queues them.
// Depends on tmb_pkg.
`default_nettype none
module tmb_front
	import tmb_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic [1:0]           s_tuser,
	output item_t                     item,
	output logic                      item_valid,
	input  wire logic                 item_pop
);

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;

	always_comb begin
		cls.mode      = s_tuser;
		cls.delta     = s_tdata[31] ? 31'd0 : s_tdata[30:0];
		cls.period    = s_tdata[62:32];
		cls.period_ok = !s_tdata[63] && (s_tdata[62:32] != 31'd0);
		cls.limit     = s_tdata[79:64];
		cls.idx       = s_tdata[83:80];
	end

	assign s_tready   = (cnt_q != 2'd2);
	// unused mode gives no result, so it never enters the queue
	assign push       = s_tvalid && s_tready && (s_tuser != MODE_NONE);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (item_pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, item_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/tmb_back.sv */
// Back end: slot storage, tick walk with a radix-2 divider, result buffer.
// Depends on tmb_pkg; fed by tmb_front.
`default_nettype none
module tmb_back
	import tmb_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire item_t                item,
	input  wire logic                 item_valid,
	output logic                      item_pop,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,
	output logic [1:0]                m_tuser,
	output logic                      m_tlast
);

	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int EN  = SLOTS + 1;
	localparam int EIW = $clog2(EN);
	localparam int EW  = $clog2(EN + 1);

	logic [30:0] per_q   [SLOTS];
	logic [31:0] el_q    [SLOTS];
	logic [15:0] lim_q   [SLOTS];
	logic [15:0] fired_q [SLOTS];
	logic [SLOTS-1:0] act_q;
	logic [CW-1:0]    cnt_q;

	state_t      state_q, state_d;
	logic [SW-1:0] slot_q;
	item_t       item_q;
	logic [32:0] dvd_q;
	logic [31:0] rem_q;
	logic [32:0] quo_q;
	logic [5:0]  step_q;
	event_t      ev_q [EN];
	logic [EW-1:0] ev_n_q;
	logic [EW-1:0] rd_q;

	// slot datapath
	logic [30:0] cur_p;
	logic [32:0] el_sum;
	logic [32:0] trial;
	logic        ge;
	logic [32:0] trial_sub;
	logic        last_slot;
	logic [15:0] lim, fr, remain;
	logic        capped, emit_fire;
	logic [30:0] fire_cnt;
	logic [SW+3:0] slot_w;

	// add / cancel
	logic          free_found;
	logic [SW-1:0] free_idx;
	logic          add_ok;
	logic [SW+3:0] idx_w;
	logic          cancel_ok;
	logic [CW+4:0] at_w;
	event_t        ev_out;

	assign cur_p     = per_q[slot_q];
	assign el_sum    = {1'b0, el_q[slot_q]} + {2'b00, item_q.delta};
	assign trial     = {rem_q, dvd_q[32]};
	assign ge        = (trial >= {2'b00, cur_p});
	assign trial_sub = trial - {2'b00, cur_p};
	assign last_slot = (slot_q == SW'(SLOTS - 1));
	assign slot_w    = {4'b0000, slot_q};

	assign lim       = lim_q[slot_q];
	assign fr        = fired_q[slot_q];
	assign remain    = (lim > fr) ? (lim - fr) : 16'd0;
	assign capped    = (lim != 16'd0) && (quo_q >= {17'd0, remain});
	assign emit_fire = capped || (quo_q != 33'd0);
	always_comb begin
		if (capped) begin
			fire_cnt = {15'd0, remain};
		end else if (quo_q[32:31] != 2'b00) begin
			fire_cnt = FIRE_MAX;
		end else begin
			fire_cnt = quo_q[30:0];
		end
	end

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!act_q[i]) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

	assign add_ok    = item.period_ok && free_found;
	assign idx_w     = {{SW{1'b0}}, item.idx};
	assign cancel_ok = (idx_w < (SW + 4)'(SLOTS)) && act_q[idx_w[SW-1:0]];

	always_comb begin
		state_d  = state_q;
		item_pop = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					state_d  = (item.mode == MODE_TICK) ? ST_SCAN : ST_EMIT;
				end
			end
			ST_SCAN: begin
				if (!act_q[slot_q]) begin
					state_d = last_slot ? ST_DONE : ST_SCAN;
				end else if (el_sum < {2'b00, cur_p}) begin
					state_d = ST_CAP;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == 6'd1) begin
					state_d = ST_CAP;
				end
			end
			ST_CAP: begin
				state_d = last_slot ? ST_DONE : ST_SCAN;
			end
			ST_DONE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				m_tvalid = 1'b1;
				if (m_tready && m_tlast) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= '0;
			cnt_q  <= '0;
			slot_q <= '0;
			ev_n_q <= '0;
			rd_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					slot_q <= '0;
					rd_q   <= '0;
					ev_n_q <= (item_valid && item.mode != MODE_TICK) ? EW'(1) : '0;
					if (item_valid && item.mode == MODE_ADD && add_ok) begin
						act_q[free_idx] <= 1'b1;
						cnt_q           <= cnt_q + CW'(1);
					end
					if (item_valid && item.mode == MODE_CANCEL && cancel_ok) begin
						act_q[idx_w[SW-1:0]] <= 1'b0;
						cnt_q                <= cnt_q - CW'(1);
					end
				end
				ST_SCAN: begin
					if (!act_q[slot_q] && !last_slot) begin
						slot_q <= slot_q + SW'(1);
					end
				end
				ST_CAP: begin
					if (capped) begin
						act_q[slot_q] <= 1'b0;
						cnt_q         <= cnt_q - CW'(1);
					end
					if (emit_fire) begin
						ev_n_q <= ev_n_q + EW'(1);
					end
					if (!last_slot) begin
						slot_q <= slot_q + SW'(1);
					end
				end
				ST_DONE: begin
					ev_n_q <= ev_n_q + EW'(1);
				end
				ST_EMIT: begin
					if (m_tready) begin
						rd_q <= rd_q + EW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_q <= item;
					if (item.mode == MODE_ADD) begin
						if (add_ok) begin
							per_q[free_idx]   <= item.period;
							el_q[free_idx]    <= 32'd0;
							lim_q[free_idx]   <= item.limit;
							fired_q[free_idx] <= 16'd0;
						end
						ev_q[0].kind  <= KIND_ADD;
						ev_q[0].slot  <= add_ok ? 4'({4'b0000, free_idx}) : 4'd0;
						ev_q[0].ok    <= add_ok;
						ev_q[0].count <= '0;
						ev_q[0].fin   <= 1'b0;
					end else begin
						ev_q[0].kind  <= KIND_CANCEL;
						ev_q[0].slot  <= item.idx;
						ev_q[0].ok    <= cancel_ok;
						ev_q[0].count <= '0;
						ev_q[0].fin   <= 1'b0;
					end
				end
			end
			ST_SCAN: begin
				quo_q <= '0;
				if (el_sum < {2'b00, cur_p}) begin
					rem_q <= el_sum[31:0];
				end else begin
					rem_q  <= '0;
					dvd_q  <= el_sum;
					step_q <= DIV_STEPS;
				end
			end
			ST_DIV: begin
				rem_q  <= ge ? trial_sub[31:0] : trial[31:0];
				dvd_q  <= {dvd_q[31:0], 1'b0};
				quo_q  <= {quo_q[31:0], ge};
				step_q <= step_q - 6'd1;
			end
			ST_CAP: begin
				if (!capped) begin
					el_q[slot_q]    <= rem_q;
					fired_q[slot_q] <= fr + quo_q[15:0];
				end
				if (emit_fire) begin
					ev_q[ev_n_q[EIW-1:0]].kind  <= KIND_FIRE;
					ev_q[ev_n_q[EIW-1:0]].slot  <= slot_w[3:0];
					ev_q[ev_n_q[EIW-1:0]].ok    <= 1'b0;
					ev_q[ev_n_q[EIW-1:0]].count <= fire_cnt;
					ev_q[ev_n_q[EIW-1:0]].fin   <= capped;
				end
			end
			ST_DONE: begin
				ev_q[ev_n_q[EIW-1:0]].kind  <= KIND_DONE;
				ev_q[ev_n_q[EIW-1:0]].slot  <= 4'd0;
				ev_q[ev_n_q[EIW-1:0]].ok    <= 1'b0;
				ev_q[ev_n_q[EIW-1:0]].count <= '0;
				ev_q[ev_n_q[EIW-1:0]].fin   <= 1'b0;
			end
			default: ;
		endcase
	end

	// results leave only after the item is finished, so the count is final
	assign ev_out  = ev_q[rd_q[EIW-1:0]];
	assign at_w    = {5'b00000, cnt_q};
	assign m_tuser = ev_out.kind;
	assign m_tlast = ((rd_q + EW'(1)) == ev_n_q);
	assign m_tdata = {6'd0, at_w[4:0], ev_out.fin, ev_out.count, ev_out.ok, ev_out.slot};

endmodule
`default_nettype wire

/* hdl/multi_slot_repeat_timer_bank_unit.sv */
// Timer bank top. Items are handled one at a time. Add/cancel: 1 result, whose transfer
// follows the input transfer via the queue slot, then the back end pop once it is idle.
// Tick: per slot a scan state if inactive, scan then capture if no fire, scan, the
// 33-step radix-2 divider and capture with a division; then a tick-done state, then one
// result per cycle while the receiver is ready. A 2-entry queue accepts meanwhile until full.
// Reset (arst_n low, async): all slots free, active count zero, queues empty.
`default_nettype none
`include "assert_macros.svh"
module multi_slot_repeat_timer_bank_unit
	import tmb_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// time_delta[31:0], period[63:32], repeat_limit[79:64], slot_index[83:80]
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// mode[1:0]
	input  wire logic [1:0]           s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// slot[3:0], ok[4], fire_count[35:5], finished[36], active_total[41:37]
	output logic [M_TDATA_W-1:0]      m_tdata,
	// kind[1:0]
	output logic [1:0]                m_tuser,
	output logic                      m_tlast
);

	item_t item;
	logic  item_valid;
	logic  item_pop;

	// front: classify and buffer transfers
	tmb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop)
	);

	// back: slot state, divider walk, result buffer
	tmb_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	`TMB_ASSERT_NOW(a_done_is_last, m_tvalid && m_tuser == KIND_DONE, m_tlast)
	`TMB_ASSERT_NOW(a_fire_not_last, m_tvalid && m_tuser == KIND_FIRE, !m_tlast)
	`TMB_ASSERT_NOW(a_add_fail_slot0, m_tvalid && m_tuser == KIND_ADD && !m_tdata[4],
		m_tdata[3:0] == 4'd0)
	`TMB_ASSERT_NOW(a_count_bound, m_tvalid, m_tdata[41:37] <= 5'(SLOTS))

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for multi_slot_repeat_timer_bank_unit.
// Drives add, cancel and tick transfers with random gaps and stalls, predicts every result
// with a scoreboard class holding its own copy of the timer bank; depends on tmb_pkg.
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import tmb_pkg::*;

	localparam int NSLOT = 16;
	localparam int LIMIT_CYCLES = 1500000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic        ok;
		logic [30:0] count;
		logic        fin;
		logic [4:0]  total;
		logic        last;
	} timer_event_t;

	// Timer bank predictor plus the queue of expected events.
	class timer_scoreboard;
		logic [30:0] period_q[NSLOT];
		logic [31:0] elapsed_q[NSLOT];
		logic [15:0] limit_q[NSLOT];
		logic [15:0] fired_q[NSLOT];
		bit          busy_q[NSLOT];
		int          in_use;
		timer_event_t pending[$];
		int          errors;
		int          checked;

		function void clear_state();
			for (int s = 0; s < NSLOT; s++) begin
				period_q[s] = '0;
				elapsed_q[s] = '0;
				limit_q[s] = '0;
				fired_q[s] = '0;
				busy_q[s] = 0;
			end
			in_use = 0;
		endfunction

		function void release_slot(int s);
			period_q[s] = '0;
			elapsed_q[s] = '0;
			limit_q[s] = '0;
			fired_q[s] = '0;
			busy_q[s] = 0;
			if (in_use > 0)
				in_use--;
		endfunction

		// Accepted input transfer: compute the events it causes.
		function void note_input(logic [1:0] mode, logic [31:0] delta, logic [31:0] per,
				logic [15:0] lim, logic [3:0] idx);
			timer_event_t evs[$];
			timer_event_t e;
			logic [63:0] el, p, fires, remain;
			bit fin;
			bit ok;
			int slot_got;
			if (mode == MODE_TICK) begin
				for (int s = 0; s < NSLOT; s++) begin
					if (!busy_q[s])
						continue;
					fin = 0;
					p = period_q[s];
					el = elapsed_q[s] + (delta[31] ? 64'd0 : 64'(delta));
					fires = (p != 0) ? el / p : 0;
					if (limit_q[s] != 0) begin
						remain = (limit_q[s] > fired_q[s]) ? 64'(limit_q[s] - fired_q[s]) : 0;
						if (fires >= remain) begin
							fires = remain;
							fin = 1;
						end
					end
					el = el - fires * p;
					elapsed_q[s] = el[31:0];
					fired_q[s] = fired_q[s] + fires[15:0];
					if (fin)
						release_slot(s);
					if (fires > 0 || fin) begin
						e = '0;
						e.kind = KIND_FIRE;
						e.slot = s[3:0];
						e.count = (fires > 64'h7FFF_FFFF) ? FIRE_MAX : fires[30:0];
						e.fin = fin;
						evs.push_back(e);
					end
				end
				e = '0;
				e.kind = KIND_DONE;
				evs.push_back(e);
			end else if (mode == MODE_ADD) begin
				ok = 0;
				slot_got = 0;
				if (in_use < NSLOT && !per[31] && per != 0) begin
					for (int s = 0; s < NSLOT; s++) begin
						if (busy_q[s])
							continue;
						period_q[s] = per[30:0];
						elapsed_q[s] = '0;
						limit_q[s] = lim;
						fired_q[s] = '0;
						busy_q[s] = 1;
						in_use++;
						slot_got = s;
						ok = 1;
						break;
					end
				end
				e = '0;
				e.kind = KIND_ADD;
				e.slot = slot_got[3:0];
				e.ok = ok;
				evs.push_back(e);
			end else if (mode == MODE_CANCEL) begin
				ok = 0;
				if (busy_q[idx]) begin
					release_slot(idx);
					ok = 1;
				end
				e = '0;
				e.kind = KIND_CANCEL;
				e.slot = idx;
				e.ok = ok;
				evs.push_back(e);
			end
			foreach (evs[k]) begin
				evs[k].total = in_use[4:0];
				evs[k].last = (k == evs.size() - 1);
				pending.push_back(evs[k]);
			end
		endfunction

		function void report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
		endfunction

		// Accepted output transfer: compare against the oldest expectation.
		function void check_event(timer_event_t got);
			timer_event_t want;
			if (pending.size() == 0) begin
				report("unexpected event kind", got.kind, 0);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.kind !== want.kind) report("kind", got.kind, want.kind);
			if (got.slot !== want.slot) report("slot", got.slot, want.slot);
			if (got.ok !== want.ok) report("ok", got.ok, want.ok);
			if (got.count !== want.count) report("fire_count", got.count, want.count);
			if (got.fin !== want.fin) report("finished", got.fin, want.fin);
			if (got.total !== want.total) report("active_total", got.total, want.total);
			if (got.last !== want.last) report("last", got.last, want.last);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	wire  s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // time_delta, period, repeat_limit, slot_index
	logic [1:0] s_tuser;             // mode
	wire  m_tvalid;
	logic m_tready;
	wire  [M_TDATA_W-1:0] m_tdata;   // slot, ok, fire_count, finished, active_total
	wire  [1:0] m_tuser;             // kind
	wire  m_tlast;

	timer_scoreboard sb;
	int  cycles;
	bit  hold_go;        // stimulus asks for the long receiver stall
	bit  hold_sink;      // long receiver stall, timed by its own process
	int  fire_seen;

	multi_slot_repeat_timer_bank_unit #(.SLOTS(NSLOT)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Send one item: random gap, then hold valid until the transfer happens.
	// Valid stays high after the transfer when the next item follows with no gap.
	task automatic send_item(logic [1:0] mode, logic [31:0] delta, logic [31:0] per,
			logic [15:0] lim, logic [3:0] idx, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {4'b0, idx, lim, per, delta};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_input(mode, delta, per, lim, idx);
	endtask

	task automatic add_timer(logic [31:0] per, logic [15:0] lim);
		send_item(MODE_ADD, $urandom, per, lim, 4'($urandom));
	endtask

	task automatic tick(logic [31:0] delta);
		send_item(MODE_TICK, delta, $urandom, 16'($urandom), 4'($urandom));
	endtask

	task automatic cancel(logic [3:0] idx);
		send_item(MODE_CANCEL, $urandom, $urandom, 16'($urandom), idx);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stall per transfer, or a long hold while hold_sink is set.
	initial begin
		int stall;
		timer_event_t got;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
			if (stall > 0 || hold_sink) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (hold_sink)
					@(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			got.kind = m_tuser;
			got.slot = m_tdata[3:0];
			got.ok = m_tdata[4];
			got.count = m_tdata[35:5];
			got.fin = m_tdata[36];
			got.total = m_tdata[41:37];
			got.last = m_tlast;
			if (got.kind == KIND_FIRE)
				fire_seen++;
			sb.check_event(got);
		end
	end

	// Timeout watchdog.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("timeout after %0d cycles", cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	// Long stall of the receiver, counted in its own process while the sender keeps going.
	initial begin
		wait (hold_go);
		hold_sink = 1'b1;
		repeat (600) @(posedge clk);
		hold_sink = 1'b0;
	end

	initial begin
		int n_items;
		int r;
		sb = new();
		sb.clear_state();
		sb.errors = 0;
		sb.checked = 0;
		fire_seen = 0;
		hold_go = 1'b0;
		hold_sink = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_TICK;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty tick, rejected adds, cancel of a free slot, extremes.
		tick(32'd0);
		add_timer(32'd0, 16'd1);
		add_timer(32'h8000_0000, 16'd1);
		add_timer(32'hFFFF_FFFF, 16'd3);
		cancel(4'd15);
		add_timer(32'd1, 16'd0);           // fires every tick unit, forever
		add_timer(32'd3, 16'd2);
		add_timer(32'h7FFF_FFFF, 16'hFFFF);
		add_timer(32'd5, 16'd1);
		tick(32'h8000_0000);               // negative delta is clamped
		tick(32'd4);
		tick(32'h7FFF_FFFF);               // huge delta, limits cap fires
		cancel(4'd0);
		cancel(4'd0);
		for (int i = 0; i < 16; i++)       // fill the bank, then overflow
			add_timer($urandom_range(1, 20), 16'($urandom_range(0, 3)));
		tick(32'd100);
		drain();

		// Random part: the receiver hold starts early, so the input queue fills and stalls.
		n_items = 0;
		while (n_items < 130) begin
			r = $urandom_range(0, 9);
			if (r < 3)
				add_timer((r == 0) ? $urandom : $urandom_range(1, 40),
					(r == 1) ? 16'($urandom) : 16'($urandom_range(0, 4)));
			else if (r < 5)
				cancel(4'($urandom));
			else if (r < 9)
				tick(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 60));
			else
				send_item(MODE_NONE, $urandom, $urandom, 16'($urandom), 4'($urandom), 1);
			if (r != 9)
				n_items++;
			if (n_items == 20)
				hold_go = 1'b1;
			if (n_items == 80)
				drain();                   // sender pauses until all results are back
		end

		drain();
		repeat (700) @(posedge clk);
		$display("covered %0d items, %0d events checked, %0d fire events", n_items,
			sb.checked, fire_seen);
		$display("including full bank, rejected adds, clamped ticks and a long output stall");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
